// File: rtl/core/pbrle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PackBits encoder.
// No dependencies; imported by pbrle_ctrl, pbrle_packer and the top level.
package pbrle_pkg;

	localparam logic [7:0] END_MARK   = 8'h80;
	localparam logic [7:0] RUN_OF_TWO = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_RUN,
		ST_LIT,
		ST_MARK
	} state_t;

	// one encoded byte handed from the sequencer to the word packer
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       fin;   // last byte caused by this input word
		logic       mark;  // byte is the end marker
	} push_t;

endpackage

// File: rtl/core/pbrle_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pbrle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/pbrle_packer.sv
`timescale 1ns / 1ps
// Packs encoded bytes into four-lane words and holds them in the output register.
// Depends on pbrle_pkg.
module pbrle_packer (
	input  logic             clk,
	input  logic             arst_n,
	input  pbrle_pkg::push_t push,
	output logic             push_rdy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_lane0,
	output logic [7:0]       out_lane1,
	output logic [7:0]       out_lane2,
	output logic [7:0]       out_lane3,
	output logic [2:0]       byte_count,
	output logic             burst_last,
	output logic             stream_done
);
	import pbrle_pkg::*;

	logic [7:0] acc_q [4];
	logic [1:0] cnt_q;
	logic       out_valid_q;
	logic [7:0] lane_q [4];
	logic [1:0] ocnt_q;
	logic       last_q;
	logic       done_q;

	logic out_free;
	logic take;
	logic word;

	assign out_free = !out_valid_q || out_ready;
	assign push_rdy = out_free || (cnt_q != 2'd3 && !push.fin);
	assign take     = push.vld && push_rdy;
	assign word     = take && (cnt_q == 2'd3 || push.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= word ? 2'd0 : cnt_q + 2'd1;
			end
			if (word) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q[cnt_q] <= push.data;
		end
		if (word) begin
			for (int j = 0; j < 4; j++) begin
				if (2'(j) == cnt_q) begin
					lane_q[j] <= push.data;
				end else if (2'(j) < cnt_q) begin
					lane_q[j] <= acc_q[j];
				end else begin
					lane_q[j] <= 8'd0;
				end
			end
			ocnt_q <= cnt_q;
			last_q <= push.fin;
			done_q <= push.fin && push.mark;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_lane0   = lane_q[0];
	assign out_lane1   = lane_q[1];
	assign out_lane2   = lane_q[2];
	assign out_lane3   = lane_q[3];
	assign byte_count  = {1'b0, ocnt_q} + 3'd1;
	assign burst_last  = last_q;
	assign stream_done = done_q;

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count != 3'd4 |-> burst_last)
		else $error("partial word not at end of burst");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> burst_last && byte_count >= 3'd1)
		else $error("end marker word not last of burst");

endmodule

// File: rtl/core/pbrle_ctrl.sv
`timescale 1ns / 1ps
// Record state and emit sequencer: updates the pending record per input word
// and streams headers and literal bytes out of the store. Depends on pbrle_pkg.
module pbrle_ctrl #(
	parameter int MAX_RECORD_LEN = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              stream_end,
	output pbrle_pkg::push_t                  push,
	input  logic                              push_rdy,
	output logic                              ram_we,
	output logic [$clog2(MAX_RECORD_LEN)-1:0] ram_waddr,
	output logic [7:0]                        ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(MAX_RECORD_LEN)-1:0] ram_raddr,
	input  logic [7:0]                        ram_rdata
);
	import pbrle_pkg::*;

	localparam int         AW       = $clog2(MAX_RECORD_LEN);
	localparam int         CW       = AW + 1;
	localparam logic [7:0] LIT_FULL = 8'(MAX_RECORD_LEN - 1);
	localparam logic [7:0] RUN_FULL = 8'(257 - MAX_RECORD_LEN);

	state_t        state_q, state_d;
	logic [7:0]    count_q, count_d;
	logic          pending_q, pending_d;
	logic [7:0]    last_q, last_d;
	logic          end_q, end_d;
	logic          phase_b_q, phase_b_d;
	logic [7:0]    rec_hdr_q, rec_hdr_d;
	logic [7:0]    rec_byte_q, rec_byte_d;
	logic [CW-1:0] iss_q, iss_d;
	logic          dv_q, dv_d;

	logic          flush_a;
	logic [7:0]    hdr_a;
	logic [7:0]    cnt_new;
	logic          wr_ext;
	logic          wr_zero;
	logic [CW-1:0] lit_n;
	logic          body_fin;
	logic          body_done;
	logic          push_ok;
	logic          adv;

	assign lit_n    = CW'(rec_hdr_q[AW-1:0]) + CW'(1);
	assign body_fin = !phase_b_q && !end_q;

	// next record state for the incoming byte
	always_comb begin
		flush_a = 1'b0;
		hdr_a   = count_q;
		cnt_new = count_q;
		wr_ext  = 1'b0;
		wr_zero = 1'b0;
		if (!pending_q) begin
			cnt_new = 8'd0;
			wr_zero = 1'b1;
		end else if (count_q[7]) begin
			if (last_q == data_byte && count_q != RUN_FULL) begin
				cnt_new = count_q - 8'd1;
			end else begin
				flush_a = 1'b1;
				cnt_new = 8'd0;
			end
		end else if (last_q != data_byte) begin
			if (count_q >= LIT_FULL) begin
				flush_a = 1'b1;
				cnt_new = 8'd0;
			end else begin
				cnt_new = count_q + 8'd1;
				wr_ext  = 1'b1;
			end
		end else if (count_q == 8'd0) begin
			cnt_new = RUN_OF_TWO;
		end else begin
			// the byte before this one moves into the new run
			flush_a = 1'b1;
			hdr_a   = count_q - 8'd1;
			cnt_new = RUN_OF_TWO;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pending_d  = pending_q;
		last_d     = last_q;
		end_d      = end_q;
		phase_b_d  = phase_b_q;
		rec_hdr_d  = rec_hdr_q;
		rec_byte_d = rec_byte_q;
		iss_d      = iss_q;
		dv_d       = dv_q;
		in_ready   = 1'b0;
		push       = '0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = last_q;
		ram_re     = 1'b0;
		ram_raddr  = iss_q[AW-1:0];
		body_done  = 1'b0;
		push_ok    = 1'b0;
		adv        = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					last_d    = data_byte;
					count_d   = cnt_new;
					pending_d = 1'b1;
					end_d     = stream_end;
					ram_we    = wr_ext || wr_zero;
					ram_waddr = wr_ext ? cnt_new[AW-1:0] : '0;
					ram_wdata = data_byte;
					if (flush_a) begin
						rec_hdr_d  = hdr_a;
						rec_byte_d = last_q;
						phase_b_d  = 1'b0;
						state_d    = ST_HDR;
					end else if (stream_end) begin
						rec_hdr_d  = cnt_new;
						rec_byte_d = data_byte;
						phase_b_d  = 1'b1;
						pending_d  = 1'b0;
						count_d    = 8'd0;
						state_d    = ST_HDR;
					end
				end
			end
			ST_HDR: begin
				push.vld  = 1'b1;
				push.data = rec_hdr_q;
				if (push_rdy) begin
					iss_d   = '0;
					dv_d    = 1'b0;
					state_d = rec_hdr_q[7] ? ST_RUN : ST_LIT;
				end
			end
			ST_RUN: begin
				push.vld  = 1'b1;
				push.data = rec_byte_q;
				push.fin  = body_fin;
				body_done = push_rdy;
			end
			ST_LIT: begin
				push.vld  = dv_q;
				push.data = ram_rdata;
				push.fin  = body_fin && iss_q == lit_n;
				push_ok   = dv_q && push_rdy;
				adv       = iss_q != lit_n && (!dv_q || push_ok);
				ram_re    = adv;
				iss_d     = iss_q + CW'(adv);
				dv_d      = adv || (dv_q && !push_ok);
				body_done = push_ok && iss_q == lit_n;
			end
			ST_MARK: begin
				push.vld  = 1'b1;
				push.data = END_MARK;
				push.fin  = 1'b1;
				push.mark = 1'b1;
				if (push_rdy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// store[0] takes the new byte only after the closed record was read out
		if (body_done) begin
			if (phase_b_q) begin
				state_d = ST_MARK;
			end else begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = last_q;
				if (end_q) begin
					rec_hdr_d  = count_q;
					rec_byte_d = last_q;
					phase_b_d  = 1'b1;
					pending_d  = 1'b0;
					count_d    = 8'd0;
					state_d    = ST_HDR;
				end else begin
					state_d = ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= 8'd0;
			pending_q <= 1'b0;
			end_q     <= 1'b0;
			phase_b_q <= 1'b0;
			iss_q     <= '0;
			dv_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			pending_q <= pending_d;
			end_q     <= end_d;
			phase_b_q <= phase_b_d;
			iss_q     <= iss_d;
			dv_q      <= dv_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q     <= last_d;
		rec_hdr_q  <= rec_hdr_d;
		rec_byte_q <= rec_byte_d;
	end

	a_quiet_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !flush_a && !stream_end |=> in_ready)
		else $error("word closing no record stalled the input");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIT |-> iss_q <= lit_n)
		else $error("literal read past record length");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != ST_IDLE |-> body_done && ram_waddr == '0)
		else $error("store written outside record start");

endmodule

// File: rtl/core/packbits_run_length_encoder_top.sv
`timescale 1ns / 1ps
// PackBits run-length encoder, top level.
// Depends on pbrle_pkg, pbrle_ram, pbrle_ctrl and pbrle_packer.
//
// Input channel (in_valid/in_ready) takes one raw byte per word, stream_end
// marks the final byte. Output channel (out_valid/out_ready) delivers encoded
// bytes packed four lanes per word, byte_count lanes valid, unused lanes 0.
// burst_last flags the last output word caused by one input word and
// stream_done the word holding the 0x80 end marker.
//
// A byte that closes no record is taken without holding the input, back to
// back. A byte that closes a record holds the input while the record is
// sent: the header, then the run byte, or the literal bytes read out of the
// literal store (one registered read port, one byte per cycle while the
// packer accepts). An end byte adds the final record and the end marker.
// Output words are assembled as bytes arrive; the output register lets the
// next word form while one waits. When the receiver stalls, the byte stream
// out of the store stops and resumes without loss.
//
// Reset empties the encoder at once; the literal store is not cleared and
// only written entries are ever read.
module packbits_run_length_encoder_top #(
	parameter int MAX_RECORD_LEN = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_lane0,
	output logic [7:0] out_lane1,
	output logic [7:0] out_lane2,
	output logic [7:0] out_lane3,
	output logic [2:0] byte_count,
	output logic       burst_last,
	output logic       stream_done
);
	import pbrle_pkg::*;

	localparam int AW = $clog2(MAX_RECORD_LEN);

	push_t         push;
	logic          push_rdy;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	pbrle_ram #(
		.WIDTH(8),
		.DEPTH(MAX_RECORD_LEN)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pbrle_ctrl #(
		.MAX_RECORD_LEN(MAX_RECORD_LEN)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.stream_end(stream_end),
		.push      (push),
		.push_rdy  (push_rdy),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	pbrle_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rdy   (push_rdy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_lane0  (out_lane0),
		.out_lane1  (out_lane1),
		.out_lane2  (out_lane2),
		.out_lane3  (out_lane3),
		.byte_count (byte_count),
		.burst_last (burst_last),
		.stream_done(stream_done)
	);

endmodule

// File: sim/tb_packbits_run_length_encoder_top.sv
`timescale 1ns / 1ps
// Testbench for the PackBits run-length encoder top level.
// Depends on pbrle_pkg and packbits_run_length_encoder_top; predicts encoded
// words per input byte and checks every output word in order.
module tb_packbits_run_length_encoder_top;

	import pbrle_pkg::*;

	localparam logic [7:0] LIT_FULL     = 8'd127;
	localparam logic [7:0] RUN_FULL     = 8'h81;
	localparam int         RANDOM_ITEMS = 30;
	localparam int         DRAIN_CYCLES = 64;
	localparam int         CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [7:0] lane0;
		logic [7:0] lane1;
		logic [7:0] lane2;
		logic [7:0] lane3;
		logic [2:0] count;
		logic       burst_last;
		logic       stream_done;
	} enc_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       stream_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_lane0;
	logic [7:0] out_lane1;
	logic [7:0] out_lane2;
	logic [7:0] out_lane3;
	logic [2:0] byte_count;
	logic       burst_last;
	logic       stream_done;

	packbits_run_length_encoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_lane0  (out_lane0),
		.out_lane1  (out_lane1),
		.out_lane2  (out_lane2),
		.out_lane3  (out_lane3),
		.byte_count (byte_count),
		.burst_last (burst_last),
		.stream_done(stream_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// encoder shadow state
	logic [7:0] lit_store [0:127];
	logic [7:0] rec_hdr = 8'h00;
	logic       rec_pending = 1'b0;
	logic [7:0] byte_buf [$];
	enc_word_t  expected_words [$];
	logic [7:0] stream_buf [$];

	int mismatch_count = 0;
	int items_sent = 0;
	int words_checked = 0;
	int streams_sent = 0;
	int cycle_count = 0;
	int burst_left = 0;

	function automatic void add_byte(input logic [7:0] b);
		byte_buf = {byte_buf, b};
	endfunction

	function automatic void emit_record();
		int n;
		int i;
		add_byte(rec_hdr);
		if (rec_hdr[7]) begin
			add_byte(lit_store[0]);
		end else begin
			n = int'(rec_hdr[6:0]) + 1;
			for (i = 0; i < n; i++)
				add_byte(lit_store[i]);
		end
	endfunction

	function automatic void start_record(input logic [7:0] b);
		lit_store[0] = b;
		rec_hdr = 8'h00;
		rec_pending = 1'b1;
	endfunction

	function automatic void encode_byte(input logic [7:0] b, input logic last);
		logic [6:0] idx;
		int         nwords;
		int         cnt;
		int         k;
		enc_word_t  w;
		byte_buf.delete();
		if (!rec_pending) begin
			start_record(b);
		end else if (rec_hdr[7]) begin
			if (lit_store[0] == b && rec_hdr != RUN_FULL) begin
				rec_hdr = rec_hdr - 8'd1;
			end else begin
				emit_record();
				start_record(b);
			end
		end else begin
			idx = rec_hdr[6:0];
			if (lit_store[idx] != b) begin
				if (rec_hdr >= LIT_FULL) begin
					emit_record();
					start_record(b);
				end else begin
					rec_hdr = rec_hdr + 8'd1;
					lit_store[rec_hdr[6:0]] = b;
				end
			end else if (rec_hdr == 8'h00) begin
				rec_hdr = RUN_OF_TWO;
			end else begin
				// equal pair closes the literal short by one byte
				rec_hdr = rec_hdr - 8'd1;
				emit_record();
				start_record(b);
				rec_hdr = RUN_OF_TWO;
			end
		end
		if (last) begin
			emit_record();
			add_byte(END_MARK);
			rec_pending = 1'b0;
			rec_hdr = 8'h00;
		end
		nwords = (byte_buf.size() + 3) / 4;
		for (k = 0; k < nwords; k++) begin
			cnt = byte_buf.size() - 4 * k;
			if (cnt > 4)
				cnt = 4;
			w.lane0 = byte_buf[4 * k];
			w.lane1 = (cnt > 1) ? byte_buf[4 * k + 1] : 8'h00;
			w.lane2 = (cnt > 2) ? byte_buf[4 * k + 2] : 8'h00;
			w.lane3 = (cnt > 3) ? byte_buf[4 * k + 3] : 8'h00;
			w.count = cnt[2:0];
			w.burst_last = (k == nwords - 1);
			w.stream_done = last && (k == nwords - 1);
			expected_words = {expected_words, w};
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("MISMATCH at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
	endtask

	// output word checker
	always @(posedge clk) begin : chk
		enc_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with none pending, lane0", int'(out_lane0), 0);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (out_lane0 !== want.lane0)
					report_mismatch("out_lane0", int'(out_lane0), int'(want.lane0));
				if (out_lane1 !== want.lane1)
					report_mismatch("out_lane1", int'(out_lane1), int'(want.lane1));
				if (out_lane2 !== want.lane2)
					report_mismatch("out_lane2", int'(out_lane2), int'(want.lane2));
				if (out_lane3 !== want.lane3)
					report_mismatch("out_lane3", int'(out_lane3), int'(want.lane3));
				if (byte_count !== want.count)
					report_mismatch("byte_count", int'(byte_count), int'(want.count));
				if (burst_last !== want.burst_last)
					report_mismatch("burst_last", int'(burst_last), int'(want.burst_last));
				if (stream_done !== want.stream_done)
					report_mismatch("stream_done", int'(stream_done), int'(want.stream_done));
			end
		end
	end

	// receiver stall pattern: free-running, periodic or random, switched now and then
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;
	int stall_len = 1;
	int stall_period = 2;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(40, 300);
			stall_period = $urandom_range(2, 10);
			stall_len = $urandom_range(1, stall_period - 1);
			stall_phase = 0;
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= (stall_phase >= stall_len);
				stall_phase = (stall_phase + 1) % stall_period;
			end
			default: begin
				out_ready <= ($urandom_range(0, 2) != 0);
			end
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycle_count,
				expected_words.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		stream_end <= last;
		encode_byte(b, last);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_stream();
		int i;
		for (i = 0; i < stream_buf.size(); i++)
			send_byte(stream_buf[i], i == stream_buf.size() - 1);
		stream_buf.delete();
		streams_sent++;
	endtask

	task automatic test_directed();
		stream_buf = '{8'h00};
		send_stream();
		stream_buf = '{8'hFF};
		send_stream();
		stream_buf = '{8'hAA, 8'hAA};
		send_stream();
		stream_buf = '{8'h01, 8'h02, 8'h03, 8'h03};
		send_stream();
		stream_buf = '{8'h10, 8'h10, 8'h10, 8'h20};
		send_stream();
		stream_buf = '{8'h55, 8'hAA, 8'h55, 8'h80, 8'h7F};
		send_stream();
		stream_buf = '{8'h00, 8'h00, 8'h01};
		send_stream();
		stream_buf = '{8'hC3, 8'hC3, 8'hC3, 8'h5A, 8'h5A};
		send_stream();
	endtask

	// full literal closed by a new byte, full run closed by the same byte
	task automatic test_record_limits();
		logic [7:0] b;
		b = 8'($urandom);
		repeat (129) begin
			stream_buf = {stream_buf, b};
			b = b ^ 8'($urandom_range(1, 255));
		end
		send_stream();
		b = 8'($urandom);
		repeat (130) stream_buf = {stream_buf, b};
		send_stream();
	endtask

	task automatic build_segment_stream();
		int         nseg;
		int         len;
		logic       is_literal;
		logic [7:0] b;
		nseg = $urandom_range(1, 6);
		repeat (nseg) begin
			is_literal = 1'($urandom_range(0, 1));
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 136) : $urandom_range(1, 9);
			b = 8'($urandom);
			repeat (len) begin
				stream_buf = {stream_buf, b};
				if (is_literal)
					b = b ^ 8'($urandom_range(1, 255));
			end
		end
	endtask

	task automatic build_noise_stream();
		int len;
		len = $urandom_range(1, 20);
		repeat (len) begin
			if ($urandom_range(0, 1))
				stream_buf = {stream_buf, 8'($urandom)};
			else
				stream_buf = {stream_buf, 8'($urandom_range(0, 1))};
		end
	endtask

	task automatic test_random_streams();
		int start_items;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) < 17)
				build_segment_stream();
			else
				build_noise_stream();
			send_stream();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_record_limits();
		test_random_streams();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes in %0d streams, checked %0d encoded words",
			items_sent, streams_sent, words_checked);
		$display("mismatches counted: %0d", mismatch_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
